// ----- sv/stt_pkg.sv -----
package stt_pkg;

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_STOP     = 2'd1,
		OP_OVERFLOW = 2'd2,
		OP_DISPATCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STOP_SCAN,
		ST_DISP_SCAN,
		ST_MOVE
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  ident;
		logic [15:0] period;
		logic        one_shot;
	} req_t;

	typedef struct packed {
		logic       fired;
		logic [7:0] fired_id;
		logic       status;
		logic       last;
	} rsp_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  ident;
		logic [15:0] period;
		logic        one_shot;
	} item_t;

	localparam logic        STATUS_OK   = 1'b0;
	localparam logic        STATUS_FULL = 1'b1;
	localparam logic [15:0] RES_RESET   = 16'd1;

endpackage

// ----- sv/stt_front.sv -----
module stt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  stt_pkg::req_t req,
	output logic          item_valid,
	output stt_pkg::item_t item,
	input  logic          item_pop
);

	stt_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	stt_pkg::item_t cls;

	always_comb begin
		cls.op       = stt_pkg::op_t'(req.operation);
		cls.ident    = req.ident;
		cls.period   = req.period;
		cls.one_shot = req.one_shot;
	end

	assign req_ready  = (cnt_q != 2'd2);
	assign push       = req_valid && req_ready;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !item_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && item_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- sv/stt_engine.sv -----
module stt_engine #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	input  logic           item_valid,
	input  stt_pkg::item_t item,
	output logic           item_pop,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output stt_pkg::rsp_t  rsp
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [7:0]  ident_q  [TABLE_DEPTH];
	logic [15:0] period_q [TABLE_DEPTH];
	logic        single_q [TABLE_DEPTH];
	logic [15:0] ticks_q  [TABLE_DEPTH];

	stt_pkg::state_t state_q, state_d;
	logic [CW-1:0]   live_q;
	logic [CW-1:0]   scan_idx_q;
	logic [15:0]     ovf_q;
	logic            pending_q;
	logic [15:0]     res_q;
	logic [7:0]      key_q;
	logic            ret_disp_q;
	logic            held_valid_q;
	logic [7:0]      held_id_q;
	logic            out_valid_q;
	stt_pkg::rsp_t   out_q;

	logic [CW-1:0] tail;
	logic [IW-1:0] rd_addr;
	logic [7:0]    cur_id;
	logic [15:0]   cur_per;
	logic          cur_single;
	logic [15:0]   cur_ticks;
	logic          idx_in;
	logic          in_window;
	logic          match;
	logic          out_free;
	logic          full;
	logic [15:0]   ovf_next;
	logic          tick;

	logic          emit;
	stt_pkg::rsp_t emit_val;
	logic          do_start;
	logic          do_ovf;
	logic          fire;
	logic          finish;
	logic          move;

	assign tail       = live_q - CW'(1);
	assign rd_addr    = (state_q == stt_pkg::ST_MOVE) ? tail[IW-1:0] : scan_idx_q[IW-1:0];
	assign cur_id     = ident_q[rd_addr];
	assign cur_per    = period_q[rd_addr];
	assign cur_single = single_q[rd_addr];
	assign cur_ticks  = ticks_q[rd_addr];
	assign idx_in     = (scan_idx_q < live_q);
	assign in_window  = (cur_ticks >= cur_per) && ({1'b0, cur_ticks} <= {cur_per, 1'b0});
	assign match      = (cur_id == key_q);
	assign out_free   = !out_valid_q || rsp_ready;
	assign full       = (live_q == CW'(TABLE_DEPTH));
	assign ovf_next   = ovf_q + 16'd1;
	assign tick       = do_ovf && (ovf_next == res_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			stt_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (item.op == stt_pkg::OP_STOP) begin
						state_d = stt_pkg::ST_STOP_SCAN;
					end else if (item.op == stt_pkg::OP_DISPATCH && pending_q) begin
						state_d = stt_pkg::ST_DISP_SCAN;
					end
				end
			end
			stt_pkg::ST_STOP_SCAN: begin
				if (!idx_in) begin
					state_d = stt_pkg::ST_IDLE;
				end else if (match) begin
					state_d = stt_pkg::ST_MOVE;
				end
			end
			stt_pkg::ST_DISP_SCAN: begin
				if (finish) begin
					state_d = stt_pkg::ST_IDLE;
				end else if (fire && cur_single) begin
					state_d = stt_pkg::ST_MOVE;
				end
			end
			stt_pkg::ST_MOVE: begin
				state_d = ret_disp_q ? stt_pkg::ST_DISP_SCAN : stt_pkg::ST_IDLE;
			end
			default: begin
				state_d = stt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_pop = 1'b0;
		emit     = 1'b0;
		emit_val = '0;
		do_start = 1'b0;
		do_ovf   = 1'b0;
		fire     = 1'b0;
		finish   = 1'b0;
		move     = 1'b0;
		case (state_q)
			stt_pkg::ST_IDLE: begin
				if (item_valid) begin
					case (item.op)
						stt_pkg::OP_START: begin
							if (out_free) begin
								item_pop        = 1'b1;
								emit            = 1'b1;
								emit_val.status = full ? stt_pkg::STATUS_FULL
								                       : stt_pkg::STATUS_OK;
								emit_val.last   = 1'b1;
								do_start        = !full;
							end
						end
						stt_pkg::OP_OVERFLOW: begin
							item_pop = 1'b1;
							do_ovf   = 1'b1;
						end
						default: begin
							item_pop = 1'b1;
						end
					endcase
				end
			end
			stt_pkg::ST_DISP_SCAN: begin
				emit_val.fired    = 1'b1;
				emit_val.fired_id = held_id_q;
				emit_val.status   = stt_pkg::STATUS_OK;
				if (!idx_in) begin
					emit_val.last = 1'b1;
					if (!held_valid_q || out_free) begin
						finish = 1'b1;
						emit   = held_valid_q;
					end
				end else if (in_window) begin
					if (!held_valid_q || out_free) begin
						fire = 1'b1;
						emit = held_valid_q;
					end
				end
			end
			stt_pkg::ST_MOVE: begin
				move = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_start) begin
			ident_q[live_q[IW-1:0]]  <= item.ident;
			period_q[live_q[IW-1:0]] <= item.period;
			single_q[live_q[IW-1:0]] <= item.one_shot;
			ticks_q[live_q[IW-1:0]]  <= 16'd0;
		end
		if (tick) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (CW'(i) < live_q) begin
					ticks_q[i] <= ticks_q[i] + 16'd1;
				end
			end
		end
		if (fire) begin
			ticks_q[scan_idx_q[IW-1:0]] <= 16'd0;
		end
		if (move) begin
			ident_q[scan_idx_q[IW-1:0]]  <= cur_id;
			period_q[scan_idx_q[IW-1:0]] <= cur_per;
			single_q[scan_idx_q[IW-1:0]] <= cur_single;
			ticks_q[scan_idx_q[IW-1:0]]  <= cur_ticks;
		end
		if (item_pop) begin
			key_q <= item.ident;
		end
		if (fire) begin
			held_id_q <= cur_id;
		end
		if (emit) begin
			out_q <= emit_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= stt_pkg::ST_IDLE;
			live_q       <= '0;
			scan_idx_q   <= '0;
			ovf_q        <= 16'd0;
			pending_q    <= 1'b0;
			res_q        <= stt_pkg::RES_RESET;
			ret_disp_q   <= 1'b0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				res_q <= cfg_wdata;
			end
			if (item_pop) begin
				scan_idx_q   <= '0;
				held_valid_q <= 1'b0;
				ret_disp_q   <= (item.op == stt_pkg::OP_DISPATCH);
			end
			if (do_start) begin
				live_q <= live_q + CW'(1);
			end
			if (do_ovf) begin
				ovf_q <= tick ? 16'd0 : ovf_next;
			end
			if (tick) begin
				pending_q <= 1'b1;
			end
			if (state_q == stt_pkg::ST_STOP_SCAN && idx_in && !match) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (state_q == stt_pkg::ST_DISP_SCAN && idx_in && !in_window) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (fire) begin
				held_valid_q <= 1'b1;
				if (!cur_single) begin
					scan_idx_q <= scan_idx_q + CW'(1);
				end
			end
			if (finish) begin
				pending_q    <= 1'b0;
				held_valid_q <= 1'b0;
			end
			if (move) begin
				live_q <= tail;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- sv/software_timer_table.sv -----
// A start result is registered for the output when the engine pops the start
// from the queue and the output is free; dispatch results follow the table scan,
// one entry per cycle while the output takes results, with a move step for each
// one-shot removal. Stop scans the table and moves the tail into the found entry;
// a 2-entry queue takes transactions meanwhile. Reset empties the table and queue,
// clears the overflow count and pending mark, and sets resolution to 1.
module software_timer_table #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	input  logic          req_valid,
	output logic          req_ready,
	input  stt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output stt_pkg::rsp_t rsp
);

	logic           item_valid;
	logic           item_pop;
	stt_pkg::item_t item;

	stt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	stt_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH = 8;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int LONG_HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	stt_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	stt_pkg::rsp_t rsp;

	bit [7:0] tmr_id [DEPTH];
	bit [15:0] tmr_period [DEPTH];
	bit tmr_single [DEPTH];
	bit [15:0] tmr_ticks [DEPTH];
	int tmr_live = 0;
	bit [15:0] ovf_count = '0;
	bit tick_pending = 1'b0;
	bit [15:0] resolution = stt_pkg::RES_RESET;
	stt_pkg::rsp_t awaited_rsp [$];

	int mismatches = 0;
	int cycles = 0;
	int starts_sent = 0;
	int full_seen = 0;
	int dispatches_sent = 0;
	int fires_seen = 0;
	int ticks_seen = 0;
	bit quiet = 1'b0;
	bit long_hold_req = 1'b0;
	int hold_left = 0;

	software_timer_table #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void drop_slot(input int slot);
		int tail;
		tail = tmr_live - 1;
		tmr_id[slot] = tmr_id[tail];
		tmr_period[slot] = tmr_period[tail];
		tmr_single[slot] = tmr_single[tail];
		tmr_ticks[slot] = tmr_ticks[tail];
		tmr_live = tail;
	endfunction

	function automatic void table_step(input stt_pkg::req_t item);
		bit [7:0] hits [$];
		bit [16:0] upper;
		int i;
		case (stt_pkg::op_t'(item.operation))
			stt_pkg::OP_START: begin
				starts_sent++;
				if (tmr_live < DEPTH) begin
					tmr_id[tmr_live] = item.ident;
					tmr_period[tmr_live] = item.period;
					tmr_single[tmr_live] = item.one_shot;
					tmr_ticks[tmr_live] = '0;
					tmr_live++;
					awaited_rsp.push_back({1'b0, 8'd0, stt_pkg::STATUS_OK, 1'b1});
				end else begin
					full_seen++;
					awaited_rsp.push_back({1'b0, 8'd0, stt_pkg::STATUS_FULL, 1'b1});
				end
			end
			stt_pkg::OP_STOP: begin
				for (i = 0; i < tmr_live; i++) begin
					if (tmr_id[i] == item.ident) begin
						drop_slot(i);
						break;
					end
				end
			end
			stt_pkg::OP_OVERFLOW: begin
				ovf_count = ovf_count + 16'd1;
				if (ovf_count == resolution) begin
					tick_pending = 1'b1;
					ticks_seen++;
					for (i = 0; i < tmr_live; i++)
						tmr_ticks[i] = tmr_ticks[i] + 16'd1;
					ovf_count = '0;
				end
			end
			default: begin
				dispatches_sent++;
				if (tick_pending) begin
					i = 0;
					while (i < tmr_live) begin
						upper = {tmr_period[i], 1'b0};
						if (tmr_ticks[i] >= tmr_period[i] && {1'b0, tmr_ticks[i]} <= upper) begin
							tmr_ticks[i] = '0;
							hits.push_back(tmr_id[i]);
							if (tmr_single[i]) begin
								drop_slot(i);
								continue;
							end
						end
						i++;
					end
					tick_pending = 1'b0;
					fires_seen += hits.size();
					foreach (hits[k])
						awaited_rsp.push_back({1'b1, hits[k], stt_pkg::STATUS_OK,
							k == hits.size() - 1});
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string label, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t ns: %s expected %0d actual %0d", $time, label, want, got);
		end
	endfunction

	always @(posedge clk) begin
		stt_pkg::rsp_t want;
		int g;
		if (rsp_valid === 1'b1 && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t ns: unexpected transaction, expected none, actual %b",
						$time, rsp);
			end else begin
				want = awaited_rsp.pop_front();
				check_field("fired", 8'(want.fired), 8'(rsp.fired));
				check_field("fired_id", want.fired_id, rsp.fired_id);
				check_field("status", 8'(want.status), 8'(rsp.status));
				check_field("last", 8'(want.last), 8'(rsp.last));
			end
		end
		if (long_hold_req) begin
			hold_left = LONG_HOLD_CYCLES;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			g = pick_gap();
			if (g > 0) begin
				hold_left = g - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input stt_pkg::req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		table_step(item);
	endtask

	task automatic send(input stt_pkg::op_t op, input bit [7:0] id, input bit [15:0] per,
			input bit single);
		stt_pkg::req_t item;
		item.operation = op;
		item.ident = id;
		item.period = per;
		item.one_shot = single;
		send_item(item);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_resolution(input bit [15:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		resolution = value;
	endtask

	task automatic clear_table();
		while (tmr_live > 0)
			send(stt_pkg::OP_STOP, tmr_id[0], 16'd0, 1'b0);
	endtask

	task automatic send_overflow();
		send(stt_pkg::OP_OVERFLOW, 8'($urandom), 16'($urandom), 1'($urandom));
	endtask

	task automatic send_random();
		stt_pkg::req_t item;
		int r;
		r = $urandom_range(0, 99);
		if (r < 28)
			item.operation = stt_pkg::OP_START;
		else if (r < 42)
			item.operation = stt_pkg::OP_STOP;
		else if (r < 75)
			item.operation = stt_pkg::OP_OVERFLOW;
		else
			item.operation = stt_pkg::OP_DISPATCH;
		if ($urandom_range(0, 3) != 0)
			item.ident = 8'($urandom_range(0, 7));
		else
			item.ident = 8'($urandom_range(0, 255));
		if (item.operation == stt_pkg::OP_STOP && tmr_live > 0 && $urandom_range(0, 3) != 0)
			item.ident = tmr_id[$urandom_range(0, tmr_live - 1)];
		r = $urandom_range(0, 9);
		if (r < 7)
			item.period = 16'($urandom_range(0, 4));
		else if (r < 9)
			item.period = 16'($urandom_range(0, 40));
		else
			item.period = 16'($urandom_range(0, 65535));
		item.one_shot = 1'($urandom_range(0, 1));
		send_item(item);
	endtask

	task automatic test_fire_order();
		send(stt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 1'b0);
		send(stt_pkg::OP_START, 8'h00, 16'h0000, 1'b0);
		send(stt_pkg::OP_START, 8'hFF, 16'hFFFF, 1'b1);
		send(stt_pkg::OP_START, 8'hA5, 16'd1, 1'b1);
		send(stt_pkg::OP_START, 8'h5A, 16'd1, 1'b0);
		send(stt_pkg::OP_START, 8'hA5, 16'd1, 1'b1);
		send(stt_pkg::OP_OVERFLOW, 8'hFF, 16'hFFFF, 1'b1);
		send(stt_pkg::OP_DISPATCH, 8'hFF, 16'hFFFF, 1'b1);
		send(stt_pkg::OP_OVERFLOW, 8'h00, 16'h0000, 1'b0);
		send(stt_pkg::OP_OVERFLOW, 8'h00, 16'h0000, 1'b0);
		send(stt_pkg::OP_START, 8'h3C, 16'h0000, 1'b1);
		send(stt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 1'b0);
	endtask

	task automatic test_full_and_stop();
		send(stt_pkg::OP_START, 8'h00, 16'd3, 1'b0);
		send(stt_pkg::OP_START, 8'h11, 16'd2, 1'b1);
		send(stt_pkg::OP_START, 8'h22, 16'd5, 1'b0);
		send(stt_pkg::OP_START, 8'h33, 16'd7, 1'b1);
		send(stt_pkg::OP_START, 8'h44, 16'd1, 1'b0);
		send(stt_pkg::OP_START, 8'h55, 16'd1, 1'b0);
		send(stt_pkg::OP_STOP, 8'h99, 16'd0, 1'b0);
		send(stt_pkg::OP_STOP, 8'h00, 16'd0, 1'b0);
	endtask

	task automatic test_long_hold();
		settle();
		quiet = 1'b1;
		@(negedge clk);
		long_hold_req = 1'b1;
		@(posedge clk);
		repeat (10)
			send(stt_pkg::OP_START, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 3)),
				1'b1);
		send(stt_pkg::OP_OVERFLOW, 8'h00, 16'd0, 1'b0);
		send(stt_pkg::OP_DISPATCH, 8'h00, 16'd0, 1'b0);
		quiet = 1'b0;
	endtask

	task automatic test_resolution_steps();
		settle();
		clear_table();
		send(stt_pkg::OP_START, 8'h77, 16'd1, 1'b0);
		send(stt_pkg::OP_START, 8'h78, 16'd0, 1'b1);
		send(stt_pkg::OP_DISPATCH, 8'h00, 16'd0, 1'b0);
		settle();
		quiet = 1'b1;
		write_resolution(16'd5);
		while (!tick_pending)
			send_overflow();
		send(stt_pkg::OP_DISPATCH, 8'h00, 16'd0, 1'b0);
		repeat (3) send_overflow();
		settle();
		write_resolution(16'd4);
		while (!tick_pending)
			send_overflow();
		send(stt_pkg::OP_DISPATCH, 8'h00, 16'd0, 1'b0);
		quiet = 1'b0;
	endtask

	task automatic test_random_phase(input bit [15:0] res, input int count, input bit steady);
		settle();
		write_resolution(res);
		quiet = steady;
		repeat (count) send_random();
		quiet = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fire_order();
		test_full_and_stop();
		test_long_hold();
		test_resolution_steps();
		test_random_phase(16'd1, 80, 1'b0);
		test_random_phase(16'd2, 80, 1'b0);
		test_random_phase(16'd3, 80, 1'b1);
		test_random_phase(16'($urandom_range(1, 5)), 80, 1'b0);
		test_random_phase(16'd1, 80, 1'b0);
		settle();
		$display("covered %0d starts (%0d on a full table), %0d dispatches, %0d entries fired",
			starts_sent, full_seen, dispatches_sent, fires_seen);
		$display("%0d ticks over resolutions 1 to 5, with the resolution changed mid-count",
			ticks_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
